FILE: sv/fdu_pkg.sv
`default_nettype none

package fdu_pkg;

    localparam logic [7:0] MARK_START = 8'h7E;
    localparam logic [7:0] ESC_A      = 8'h88;
    localparam logic [7:0] ESC_B      = 8'h81;
    localparam logic [7:0] STUFF_BYTE = 8'hFF;

    // Result kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Header byte counter codes.
    localparam logic [1:0] HDR_BYTE0 = 2'd0;
    localparam logic [1:0] HDR_BYTE1 = 2'd1;
    localparam logic [1:0] HDR_CSUM  = 2'd2;
    localparam logic [1:0] HDR_DONE  = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [6:0] frame_size;
        logic [4:0] sequence_res;
        logic [3:0] msg_type;
        logic [7:0] received_checksum;
        logic [7:0] data_byte;
        logic [6:0] byte_index;
        logic       last;
        logic       checksum_ok;
    } fdu_result_t;

endpackage

`default_nettype wire

FILE: sv/frame_deframer_unstuffer_top.sv
// Byte-stuffed frame deframer.
// Input channel: rx_valid / rx_ready carry one raw link byte per transaction.
// Output channel: res_valid / res_ready carry one result per transaction:
// one header result after the third unstuffed header byte, then one result
// per payload byte; the final one has last set and carries checksum_ok.
// Bytes outside a frame, the start marker, header bytes before the third and
// dropped stuffing bytes produce no result.
// Throughput: one byte per cycle while rx_ready is high. The frame state
// updates in the cycle a byte is taken and its result lands in a single
// output register, so res_valid shows it in the cycle after acceptance.
// rx_ready is high while the output register is empty or is being drained
// in the same cycle; when the receiver stalls with a result held, input is
// held off until that result is taken.
// Reset (rst_n low, asynchronous) returns the block to hunting for the start
// marker and empties the output register.
`default_nettype none

module frame_deframer_unstuffer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic            kind,
    output logic [6:0]      frame_size,
    output logic [4:0]      sequence_res,
    output logic [3:0]      msg_type,
    output logic [7:0]      received_checksum,
    output logic [7:0]      data_byte,
    output logic [6:0]      byte_index,
    output logic            last,
    output logic            checksum_ok
);
    import fdu_pkg::*;

    logic        accept;
    logic        core_valid;
    fdu_result_t core_res;
    fdu_result_t out_res;

    assign accept = rx_valid && rx_ready;

    fdu_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .res_valid (core_valid),
        .res       (core_res)
    );

    fdu_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && core_valid),
        .load_data (core_res),
        .slot_free (rx_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (out_res)
    );

    assign kind              = out_res.kind;
    assign frame_size        = out_res.frame_size;
    assign sequence_res      = out_res.sequence_res;
    assign msg_type          = out_res.msg_type;
    assign received_checksum = out_res.received_checksum;
    assign data_byte         = out_res.data_byte;
    assign byte_index        = out_res.byte_index;
    assign last              = out_res.last;
    assign checksum_ok       = out_res.checksum_ok;

endmodule

`default_nettype wire

FILE: sv/fdu_core.sv
`default_nettype none

module fdu_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          rx_byte,
    output logic                     res_valid,
    output fdu_pkg::fdu_result_t     res
);
    import fdu_pkg::*;

    logic        in_frame_reg,  in_frame_next;
    logic        esc_reg,       esc_next;
    logic [1:0]  hdr_cnt_reg,   hdr_cnt_next;
    logic [15:0] hdr_reg,       hdr_next;
    logic [7:0]  csum_reg,      csum_next;
    logic [7:0]  sum_reg,       sum_next;
    logic [6:0]  dcnt_reg,      dcnt_next;

    logic [6:0] hdr_size;
    logic [4:0] hdr_seq;
    logic [3:0] hdr_type;
    logic [7:0] hdr_sum;
    logic [7:0] data_sum;
    logic [7:0] idx_plus;
    logic       is_last;

    assign hdr_size = hdr_reg[15:9];
    assign hdr_seq  = {hdr_reg[8], hdr_reg[7:4]};
    assign hdr_type = hdr_reg[3:0];
    assign hdr_sum  = {1'b0, hdr_size} + {3'b000, hdr_seq} + {4'h0, hdr_type};
    assign data_sum = sum_reg + rx_byte;
    assign idx_plus = {1'b0, dcnt_reg} + 8'd1;
    assign is_last  = (idx_plus >= {1'b0, hdr_size});

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        hdr_next      = hdr_reg;
        csum_next     = csum_reg;
        sum_next      = sum_reg;
        dcnt_next     = dcnt_reg;
        res_valid     = 1'b0;

        res.kind              = KIND_HEADER;
        res.frame_size        = hdr_size;
        res.sequence_res      = hdr_seq;
        res.msg_type          = hdr_type;
        res.received_checksum = csum_reg;
        res.data_byte         = 8'h00;
        res.byte_index        = 7'd0;
        res.last              = 1'b0;
        res.checksum_ok       = 1'b0;

        if (!in_frame_reg)
        begin
            if (rx_byte == MARK_START)
            begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                hdr_cnt_next  = HDR_BYTE0;
                sum_next      = 8'h00;
                dcnt_next     = 7'd0;
            end
        end
        else if (esc_reg && rx_byte == STUFF_BYTE)
        begin
            // Stuffing byte after an escape is dropped.
            esc_next = 1'b0;
        end
        else
        begin
            esc_next = (rx_byte == ESC_A) || (rx_byte == ESC_B);
            case (hdr_cnt_reg)
                HDR_BYTE0:
                begin
                    hdr_next     = {rx_byte, 8'h00};
                    hdr_cnt_next = HDR_BYTE1;
                end
                HDR_BYTE1:
                begin
                    hdr_next     = {hdr_reg[15:8], rx_byte};
                    hdr_cnt_next = HDR_CSUM;
                end
                HDR_CSUM:
                begin
                    csum_next             = rx_byte;
                    sum_next              = hdr_sum;
                    dcnt_next             = 7'd0;
                    res_valid             = 1'b1;
                    res.received_checksum = rx_byte;
                    if (hdr_size == 7'd0)
                    begin
                        // Empty payload: the header result closes the frame.
                        res.last        = 1'b1;
                        res.checksum_ok = (hdr_sum == rx_byte);
                        in_frame_next   = 1'b0;
                        esc_next        = 1'b0;
                        hdr_cnt_next    = HDR_BYTE0;
                    end
                    else
                    begin
                        hdr_cnt_next = HDR_DONE;
                    end
                end
                default:
                begin
                    sum_next        = data_sum;
                    dcnt_next       = idx_plus[6:0];
                    res_valid       = 1'b1;
                    res.kind        = KIND_DATA;
                    res.data_byte   = rx_byte;
                    res.byte_index  = dcnt_reg;
                    res.last        = is_last;
                    res.checksum_ok = is_last && (data_sum == csum_reg);
                    if (is_last)
                    begin
                        in_frame_next = 1'b0;
                        esc_next      = 1'b0;
                        hdr_cnt_next  = HDR_BYTE0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            hdr_cnt_reg  <= HDR_BYTE0;
            hdr_reg      <= 16'h0000;
            csum_reg     <= 8'h00;
            sum_reg      <= 8'h00;
            dcnt_reg     <= 7'd0;
        end
        else if (accept)
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            hdr_reg      <= hdr_next;
            csum_reg     <= csum_next;
            sum_reg      <= sum_next;
            dcnt_reg     <= dcnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fdu_out_reg.sv
`default_nettype none

module fdu_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire fdu_pkg::fdu_result_t load_data,
    output logic                     slot_free,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output fdu_pkg::fdu_result_t     res_data
);
    import fdu_pkg::*;

    logic        valid_reg, valid_next;
    fdu_result_t data_reg;

    // The slot can take a new result when empty or when it drains this cycle.
    assign slot_free = !valid_reg || res_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/fdu_checker.sv
`default_nettype none

module fdu_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       res_valid,
    input  wire logic       res_ready,
    input  wire logic       kind,
    input  wire logic [6:0] frame_size,
    input  wire logic [7:0] data_byte,
    input  wire logic [6:0] byte_index,
    input  wire logic       last,
    input  wire logic       checksum_ok
);
    import fdu_pkg::*;

    // A result that is not taken stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_header_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_HEADER |-> data_byte == 8'h00 && byte_index == 7'd0)
        else $error("header result carries payload fields");

    a_ok_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> !checksum_ok)
        else $error("checksum_ok on a result that is not last");

    // An empty frame closes on its header; payload index stays below the size.
    a_size_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (kind == KIND_HEADER && frame_size == 7'd0 && last)
                   || (kind == KIND_HEADER && frame_size != 7'd0 && !last)
                   || (kind == KIND_DATA && byte_index < frame_size))
        else $error("result inconsistent with frame size");

endmodule

bind frame_deframer_unstuffer_top fdu_checker u_fdu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .kind        (kind),
    .frame_size  (frame_size),
    .data_byte   (data_byte),
    .byte_index  (byte_index),
    .last        (last),
    .checksum_ok (checksum_ok)
);

`default_nettype wire
